@@ hdl/universal_code_cost_accumulator_unit_defines.svh @@
// Assertion macros used by the universal code cost accumulator back end.
// Needs clk and rst in the scope of the module that uses them.
`ifndef UNIVERSAL_CODE_COST_ACCUMULATOR_UNIT_DEFINES_SVH
`define UNIVERSAL_CODE_COST_ACCUMULATOR_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define UCCA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Check that cons holds in the cycle after ante holds.
`define UCCA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

@@ hdl/ucca_pkg.sv @@
`timescale 1ns / 1ps
// Package for the universal code cost accumulator: widths, queue item type
// and the code length functions. No dependencies.
package ucca_pkg;

  localparam int GAP_BITS_DEF = 32;
  localparam int GAP_MAX      = 48;
  localparam int OCC_W        = 32;
  localparam int TOT_W        = 64;
  localparam int LEN_W        = 8;
  localparam int BL_W         = 6;
  localparam int NUM_CODES    = 7;
  localparam int QUEUE_DEPTH  = 4;
  localparam int FIX32_SHIFT  = 5;
  localparam int FIX64_SHIFT  = 6;

  typedef logic [LEN_W-1:0] len_t;
  typedef logic [TOT_W-1:0] tot_t;

  typedef struct packed {
    logic             start;
    logic             nz;
    logic [OCC_W-1:0] occ;
    len_t             gamma_len;
    len_t             sigma_len;
    len_t             delta_len;
    len_t             omega_len;
    len_t             nibble_len;
  } item_t;

  function automatic logic [BL_W-1:0] bit_len_wide(input logic [GAP_MAX-1:0] v);
    logic [BL_W-1:0] n;
    n = '0;
    for (int i = 0; i < GAP_MAX; i++) begin
      if (v[i]) begin
        n = BL_W'(i + 1);
      end
    end
    return n;
  endfunction

  function automatic len_t bit_len_narrow(input len_t v);
    len_t n;
    n = '0;
    for (int i = 0; i < LEN_W; i++) begin
      if (v[i]) begin
        n = LEN_W'(i + 1);
      end
    end
    return n;
  endfunction

  // floor(v / 3) for v below 128
  function automatic len_t div3(input len_t v);
    logic [15:0] p;
    p = 16'(v) * 16'd43;
    return LEN_W'(p >> 7);
  endfunction

  function automatic len_t omega_of(input len_t l);
    len_t len;
    len_t v;
    len_t b;
    len = len_t'(1);
    v   = '0;
    b   = '0;
    if (l > len_t'(1)) begin
      len = len + l;
      v   = l - len_t'(1);
      for (int i = 0; i < 4; i++) begin
        if (v > len_t'(1)) begin
          b   = bit_len_narrow(v);
          len = len + b;
          v   = b - len_t'(1);
        end
      end
    end
    return len;
  endfunction

endpackage

@@ hdl/ucca_front.sv @@
`timescale 1ns / 1ps
// Front end: accepts input requests, finds the bit length and the code
// lengths, and holds them for the queue. Depends on ucca_pkg.
module ucca_front import ucca_pkg::*; #(
  parameter int GAP_BITS = GAP_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic [GAP_BITS-1:0] gap_value,
  input  logic [OCC_W-1:0]    occurrences,
  input  logic                start_set,
  output logic                out_valid,
  input  logic                out_ready,
  output item_t               out_item
);

  logic            hold_valid;
  item_t           hold_item;
  item_t           calc;
  logic [BL_W-1:0] l6;
  len_t            l;
  len_t            h;

  assign in_ready  = !hold_valid || out_ready;
  assign out_valid = hold_valid;
  assign out_item  = hold_item;

  always_comb begin
    l6 = bit_len_wide(GAP_MAX'(gap_value));
    l  = LEN_W'(l6);
    h  = l - len_t'(1);
    calc.start = start_set;
    calc.occ   = occurrences;
    calc.nz    = (l6 != '0);
    if (calc.nz) begin
      calc.gamma_len  = (l << 1) - len_t'(1);
      calc.sigma_len  = ((h >> 1) + len_t'(1)) * len_t'(3) - len_t'(!h[0]);
      calc.delta_len  = (bit_len_narrow(l) << 1) - len_t'(1) + l - len_t'(1);
      calc.omega_len  = omega_of(l);
      calc.nibble_len = (div3(l) + len_t'(1)) << 2;
    end else begin
      calc.gamma_len  = '0;
      calc.sigma_len  = '0;
      calc.delta_len  = '0;
      calc.omega_len  = '0;
      calc.nibble_len = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      hold_item <= calc;
    end
  end

endmodule

@@ hdl/ucca_queue.sv @@
`timescale 1ns / 1ps
// Short request queue between the front end and the back end.
// Depends on ucca_pkg for the item type and depth.
module ucca_queue import ucca_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  item_t push_item,
  output logic  pop_valid,
  input  logic  pop_ready,
  output item_t pop_item
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);

  item_t            slots [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W:0]   count;
  logic             push;
  logic             pop;

  assign push_ready = (count != (PTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PTR_W'(1);
      end
      count <= count + (PTR_W+1)'(push) - (PTR_W+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

endmodule

@@ hdl/ucca_back.sv @@
`timescale 1ns / 1ps
// Back end: multiplies code lengths by the count, then adds the products
// to the seven running totals that also form the output register (a start item
// reloads them). Depends on ucca_pkg and the assertion macro header.
`include "universal_code_cost_accumulator_unit_defines.svh"
module ucca_back import ucca_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  item_t                    in_item,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [NUM_CODES*TOT_W-1:0] totals
);

  localparam int PROD_W = OCC_W + LEN_W;

  logic mul_valid;
  logic mul_start;
  logic mul_nz;
  tot_t prod [NUM_CODES];
  tot_t total [NUM_CODES];
  tot_t total_next [NUM_CODES];
  logic adv;
  logic mul_take;

  assign adv      = mul_valid && (!out_valid || out_ready);
  assign mul_take = !mul_valid || adv;
  assign in_ready = mul_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_valid <= 1'b0;
    end else if (mul_take) begin
      mul_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (mul_take && in_valid) begin
      mul_start <= in_item.start;
      mul_nz    <= in_item.nz;
      prod[0]   <= TOT_W'(PROD_W'(in_item.occ) * PROD_W'(in_item.gamma_len));
      prod[1]   <= TOT_W'(PROD_W'(in_item.occ) * PROD_W'(in_item.sigma_len));
      prod[2]   <= TOT_W'(PROD_W'(in_item.occ) * PROD_W'(in_item.delta_len));
      prod[3]   <= TOT_W'(PROD_W'(in_item.occ) * PROD_W'(in_item.omega_len));
      prod[4]   <= TOT_W'(PROD_W'(in_item.occ) * PROD_W'(in_item.nibble_len));
      prod[5]   <= in_item.nz ? (TOT_W'(in_item.occ) << FIX32_SHIFT) : '0;
      prod[6]   <= in_item.nz ? (TOT_W'(in_item.occ) << FIX64_SHIFT) : '0;
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CODES; i++) begin
      total_next[i] = mul_start ? prod[i] : total[i] + prod[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      for (int i = 0; i < NUM_CODES; i++) begin
        total[i] <= '0;
      end
    end else begin
      if (adv) begin
        out_valid <= 1'b1;
        for (int i = 0; i < NUM_CODES; i++) begin
          total[i] <= total_next[i];
        end
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    for (int i = 0; i < NUM_CODES; i++) begin
      totals[i*TOT_W +: TOT_W] = total[i];
    end
  end

  `UCCA_ASSERT_NOW(a_fixed_ratio, 1'b1, total[6] == (total[5] << 1), "fixed64 total not twice fixed32")
  `UCCA_ASSERT_NEXT(a_start_clear, adv && mul_start, total[0] == $past(prod[0]), "start did not clear totals")
  `UCCA_ASSERT_NEXT(a_zero_gap, adv && !mul_start && !mul_nz, total[3] == $past(total[3]) && total[0] == $past(total[0]), "zero gap changed a total")

endmodule

@@ hdl/universal_code_cost_accumulator_unit.sv @@
`timescale 1ns / 1ps
// Universal code cost accumulator, top level. Takes one request per cycle
// while the queue has room and returns the seven running code-cost totals
// after each request. The front end finds the code lengths combinationally
// and the back end has multiply and add lanes. A request passes the front
// register, which loads at the accepting edge, then the queue slot, the
// multiply register and the totals in that order. A four-entry queue lets
// the front end keep taking requests while the result side is stalled.
// Depends on ucca_pkg, ucca_front, ucca_queue and ucca_back.
module universal_code_cost_accumulator_unit import ucca_pkg::*; #(
  parameter  int GAP_BITS = GAP_BITS_DEF,
  localparam int S_DATA_W = ((GAP_BITS + OCC_W + 7) / 8) * 8,
  localparam int M_DATA_W = NUM_CODES * TOT_W
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  // gap_value, occurrences, zero fill
  input  logic [S_DATA_W-1:0] s_tdata,
  // start_set
  input  logic                s_tuser,
  output logic                m_tvalid,
  input  logic                m_tready,
  // gamma_bits, sigma_bits, delta_bits, omega_bits, nibble_bits,
  // fixed32_bits, fixed64_bits
  output logic [M_DATA_W-1:0] m_tdata
);

  logic  fq_valid;
  logic  fq_ready;
  item_t fq_item;
  logic  qb_valid;
  logic  qb_ready;
  item_t qb_item;

  ucca_front #(
    .GAP_BITS(GAP_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .gap_value  (s_tdata[GAP_BITS-1:0]),
    .occurrences(s_tdata[GAP_BITS +: OCC_W]),
    .start_set  (s_tuser),
    .out_valid  (fq_valid),
    .out_ready  (fq_ready),
    .out_item   (fq_item)
  );

  ucca_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push_valid(fq_valid),
    .push_ready(fq_ready),
    .push_item (fq_item),
    .pop_valid (qb_valid),
    .pop_ready (qb_ready),
    .pop_item  (qb_item)
  );

  ucca_back u_back (
    .clk      (clk),
    .rst      (rst),
    .in_valid (qb_valid),
    .in_ready (qb_ready),
    .in_item  (qb_item),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .totals   (m_tdata)
  );

endmodule

@@ verif/code_cost_checker.sv @@
`timescale 1ns / 1ps
// Scoreboard for the universal code cost accumulator: watches both stream channels,
// keeps its own copy of the seven running code-cost totals and compares every result.
// Depends on ucca_pkg.
module code_cost_checker import ucca_pkg::*; #(
  parameter  int GAP_W    = GAP_BITS_DEF,
  localparam int S_DATA_W = ((GAP_W + OCC_W + 7) / 8) * 8,
  localparam int M_DATA_W = NUM_CODES * TOT_W
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  input  logic                s_tready,
  // gap_value, occurrences, zero fill
  input  logic [S_DATA_W-1:0] s_tdata,
  // start_set
  input  logic                s_tuser,
  input  logic                m_tvalid,
  input  logic                m_tready,
  // gamma_bits, sigma_bits, delta_bits, omega_bits, nibble_bits,
  // fixed32_bits, fixed64_bits
  input  logic [M_DATA_W-1:0] m_tdata,
  output int                  mismatches,
  output int                  pending_results
);

  typedef enum int {
    CODE_GAMMA,
    CODE_SIGMA,
    CODE_DELTA,
    CODE_OMEGA,
    CODE_NIBBLE,
    CODE_FIX32,
    CODE_FIX64
  } code_e;

  typedef logic [M_DATA_W-1:0] totals_t;

  localparam int FIXED32_COST = 32;
  localparam int FIXED64_COST = 64;

  tot_t    running_totals [NUM_CODES];
  totals_t expected_totals_q [$];
  totals_t oldest_totals;
  code_e   code_sel;
  int      mismatch_count = 0;
  int      queued_count = 0;

  assign mismatches      = mismatch_count;
  assign pending_results = queued_count;

  function automatic int msb_len(input logic [63:0] v);
    int n;
    n = 0;
    for (int i = 0; i < 64; i++) begin
      if (v[i]) begin
        n = i + 1;
      end
    end
    return n;
  endfunction

  function automatic int omega_cost(input logic [63:0] x);
    int          len;
    int          b;
    logic [63:0] v;
    len = 1;
    v   = x;
    while (v > 64'd1) begin
      b   = msb_len(v);
      len = len + b;
      v   = 64'(b - 1);
    end
    return len;
  endfunction

  task automatic report_mismatch(input string what, input tot_t got, input tot_t want);
    $display("%0t MISMATCH %s: got %0h want %0h", $realtime, what, got, want);
    mismatch_count++;
  endtask

  task automatic add_histogram_bin(input logic [GAP_W-1:0] gap, input logic [OCC_W-1:0] occ,
                                   input logic start);
    int      l;
    int      h;
    tot_t    cost [NUM_CODES];
    totals_t snapshot;
    if (start) begin
      for (int c = 0; c < NUM_CODES; c++) begin
        running_totals[c] = '0;
      end
    end
    if (gap != '0) begin
      l = msb_len(64'(gap));
      h = l - 1;
      cost[CODE_GAMMA]  = tot_t'(2 * l - 1);
      cost[CODE_SIGMA]  = tot_t'((h / 2 + 1) * 3 - ((h % 2 == 0) ? 1 : 0));
      cost[CODE_DELTA]  = tot_t'(2 * msb_len(64'(l)) - 1 + l - 1);
      cost[CODE_OMEGA]  = tot_t'(omega_cost(64'(gap)));
      cost[CODE_NIBBLE] = tot_t'((l / 3 + 1) * 4);
      cost[CODE_FIX32]  = tot_t'(FIXED32_COST);
      cost[CODE_FIX64]  = tot_t'(FIXED64_COST);
      for (int c = 0; c < NUM_CODES; c++) begin
        running_totals[c] = running_totals[c] + tot_t'(occ) * cost[c];
      end
    end
    for (int c = 0; c < NUM_CODES; c++) begin
      snapshot[c*TOT_W +: TOT_W] = running_totals[c];
    end
    expected_totals_q.push_back(snapshot);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      for (int c = 0; c < NUM_CODES; c++) begin
        running_totals[c] = '0;
      end
      expected_totals_q.delete();
    end else begin
      if (m_tvalid && m_tready) begin
        if (expected_totals_q.size() == 0) begin
          report_mismatch("result with no request pending", m_tdata[TOT_W-1:0], '0);
        end else begin
          oldest_totals = expected_totals_q.pop_front();
          for (int c = 0; c < NUM_CODES; c++) begin
            code_sel = code_e'(c);
            if (m_tdata[c*TOT_W +: TOT_W] !== oldest_totals[c*TOT_W +: TOT_W]) begin
              report_mismatch(code_sel.name(), m_tdata[c*TOT_W +: TOT_W],
                              oldest_totals[c*TOT_W +: TOT_W]);
            end
          end
        end
      end
      if (s_tvalid && s_tready) begin
        add_histogram_bin(s_tdata[GAP_W-1:0], s_tdata[GAP_W +: OCC_W], s_tuser);
      end
    end
    queued_count = expected_totals_q.size();
  end

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 1ps
// Testbench top for universal_code_cost_accumulator_unit: clock, reset, bursty
// histogram-bin stimulus, result-side stalls and the verdict.
// Depends on ucca_pkg, the accumulator RTL and code_cost_checker.
module tb import ucca_pkg::*;;

  localparam int GAP_W       = GAP_BITS_DEF;
  localparam int S_DATA_W    = ((GAP_W + OCC_W + 7) / 8) * 8;
  localparam int M_DATA_W    = NUM_CODES * TOT_W;
  localparam int RANDOM_BINS = 900;
  localparam int HOLDOFF_AT  = 300;
  localparam int HOLDOFF_LEN = 150;
  localparam int IDLE_LIMIT  = 5000;
  localparam int DRAIN_WAIT  = 16;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;
  logic                s_tuser;
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;
  int                  mismatches;
  int                  pending_results;
  int unsigned         cycle_no = 0;
  int unsigned         idle_cycles = 0;
  int                  burst_left = 0;

  universal_code_cost_accumulator_unit #(.GAP_BITS(GAP_W)) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  code_cost_checker #(.GAP_W(GAP_W)) cost_check (
    .clk             (clk),
    .rst             (rst),
    .s_tvalid        (s_tvalid),
    .s_tready        (s_tready),
    .s_tdata         (s_tdata),
    .s_tuser         (s_tuser),
    .m_tvalid        (m_tvalid),
    .m_tready        (m_tready),
    .m_tdata         (m_tdata),
    .mismatches      (mismatches),
    .pending_results (pending_results)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_no <= cycle_no + 1;
    if (!rst) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("universal_code_cost_accumulator_unit verification failed");
        $finish;
      end
    end
  end

  // offer one request; open a new burst after a random gap when the last one ran out
  task automatic send_bin(input logic [GAP_W-1:0] gap, input logic [OCC_W-1:0] occ,
                          input logic start);
    int idle;
    if (burst_left == 0) begin
      idle = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (idle > 0) begin
        s_tvalid <= 1'b0;
        s_tdata  <= S_DATA_W'({$urandom, $urandom});
        s_tuser  <= 1'($urandom);
        repeat (idle) @(posedge clk);
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 16);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= S_DATA_W'({occ, gap});
    s_tuser  <= start;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    burst_left--;
  endtask

  initial begin
    int               w;
    logic [GAP_W-1:0] gap;
    logic [OCC_W-1:0] occ;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    s_tuser  = 1'b0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_bin(32'h0000_0000, 32'hFFFF_FFFF, 1'b0);
    send_bin(32'h0000_0001, 32'h0000_0001, 1'b1);
    send_bin(32'h0000_0002, 32'h0000_0003, 1'b0);
    send_bin(32'h0000_0003, 32'hFFFF_FFFF, 1'b0);
    send_bin(32'h0000_0004, 32'h0000_0001, 1'b0);
    send_bin(32'h0000_0007, 32'h0000_0005, 1'b0);
    send_bin(32'h0000_0008, 32'h0000_0001, 1'b0);
    send_bin(32'h0000_0010, 32'h0000_0002, 1'b0);
    send_bin(32'h0000_0011, 32'h0000_0001, 1'b0);
    send_bin(32'h0000_00FF, 32'h0000_0009, 1'b0);
    send_bin(32'h0000_0100, 32'h0000_0001, 1'b0);
    send_bin(32'h0000_FFFF, 32'h0001_0000, 1'b0);
    send_bin(32'h0001_0000, 32'h0000_0001, 1'b0);
    send_bin(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_bin(32'h8000_0000, 32'hFFFF_FFFF, 1'b0);
    send_bin(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
    send_bin(32'hFFFF_FFFF, 32'h0000_0000, 1'b0);
    send_bin(32'h0000_0000, 32'h0000_0005, 1'b1);
    send_bin(32'h0000_0000, 32'h0000_0000, 1'b0);
    send_bin(32'hAAAA_AAAA, 32'h5555_5555, 1'b0);
    send_bin(32'h5555_5555, 32'hAAAA_AAAA, 1'b1);
    send_bin(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);

    for (int i = 0; i < RANDOM_BINS; i++) begin
      w   = $urandom_range(0, GAP_W);
      gap = (w == 0) ? '0 : GAP_W'(({$urandom} | 32'h8000_0000) >> (32 - w));
      case ($urandom_range(0, 9))
        0:       occ = '0;
        1:       occ = '1;
        2, 3, 4: occ = OCC_W'($urandom_range(1, 16));
        default: occ = OCC_W'($urandom >> $urandom_range(0, 31));
      endcase
      send_bin(gap, occ, ($urandom_range(0, 19) == 0));
    end
    s_tvalid <= 1'b0;

    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatches == 0) begin
      $display("universal_code_cost_accumulator_unit verification clean");
    end else begin
      $display("universal_code_cost_accumulator_unit verification failed");
    end
    $finish;
  end

  // result-side stalls: stretches of always-ready, mostly-ready, mostly-stalled and a
  // fixed duty pattern, plus one long hold-off while requests keep coming
  initial begin
    int  mode;
    int  span;
    int  step;
    bit  held_off;
    held_off = 1'b0;
    step     = 0;
    m_tready = 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (!held_off && cycle_no >= HOLDOFF_AT) begin
        m_tready <= 1'b0;
        repeat (HOLDOFF_LEN) @(posedge clk);
        held_off = 1'b1;
      end
      mode = $urandom_range(0, 3);
      span = $urandom_range(20, 120);
      repeat (span) begin
        case (mode)
          0:       m_tready <= 1'b1;
          1:       m_tready <= ($urandom_range(0, 3) != 0);
          2:       m_tready <= ($urandom_range(0, 3) == 0);
          default: m_tready <= ((step % 5) < 2);
        endcase
        step++;
        @(posedge clk);
      end
    end
  end

endmodule
